@@ design/atcc_pkg.sv @@
// Package: shared types, widths and codes for the tilt command classifier
`timescale 1ns / 1ps
package atcc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int K_W         = 16;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SUM_W       = SQ_W + 1;
    localparam int PROD_W      = SUM_W + K_W;
    localparam int LHS_W       = SQ_W + K_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = Q_IDX_W + 1;

    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [K_W-1:0] TILT_TAN_SQ_RST = K_W'(8682);
    localparam logic [2:0]     AXIS_NEGATE_RST = 3'd7;
    localparam logic [5:0]     AXIS_SELECT_RST = 6'd36;

    typedef enum logic [2:0] {
        CMD_STOP    = 3'd0,
        CMD_RIGHT   = 3'd1,
        CMD_LEFT    = 3'd2,
        CMD_BACK    = 3'd3,
        CMD_FORWARD = 3'd4,
        CMD_NONE    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        REG_TILT_TAN_SQ = 2'd0,
        REG_AXIS_NEGATE = 2'd1,
        REG_AXIS_SELECT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEL_X    = 2'd0,
        SEL_Y    = 2'd1,
        SEL_Z    = 2'd2,
        SEL_ZERO = 2'd3
    } t_axis_sel;

    typedef struct packed {
        logic [K_W-1:0] tilt_tan_sq;
        logic [2:0]     axis_negate;
        logic [5:0]     axis_select;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ design/atcc_front.sv @@
// Front pipeline: axis remap, squares, threshold product and tilt classification
`timescale 1ns / 1ps
module atcc_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [atcc_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [atcc_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [atcc_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  atcc_pkg::t_cfg                         i_cfg,
    input  atcc_pkg::t_q_status                    i_q_status,
    output logic                                   o_push,
    output atcc_pkg::t_cmd                         o_cmd
);
    import atcc_pkg::*;

    logic                   en;
    logic [SAMPLE_BITS-1:0] sel_v [3];
    logic [SAMPLE_BITS-1:0] n_mag [3];
    logic [2:0]             n_pos;
    logic [2:0]             n_nz;

    logic                   r_v1, r_v2, r_v3, r_v4;
    logic [SAMPLE_BITS-1:0] r_mag [3];
    logic [2:0]             r_pos1, r_nz1;
    logic [SQ_W-1:0]        r_sq [3];
    logic [2:0]             r_pos2, r_nz2;
    logic [SQ_W-1:0]        r_dom;
    logic [SUM_W-1:0]       r_sum;
    logic                   r_pitch3, r_pos3, r_nz3;
    logic [PROD_W-1:0]      r_prod;
    logic [LHS_W-1:0]       r_lhs;
    logic                   r_pitch4, r_pos4, r_nz4;

    logic                   n_pitch;
    logic                   over;

    assign o_push  = r_v4 && !i_q_status.full;
    assign en      = o_push || !r_v4;
    assign o_ready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (t_axis_sel'(i_cfg.axis_select[2*i +: 2]))
                SEL_X:   sel_v[i] = i_accel_x;
                SEL_Y:   sel_v[i] = i_accel_y;
                SEL_Z:   sel_v[i] = i_accel_z;
                default: sel_v[i] = '0;
            endcase
            n_nz[i]  = |sel_v[i];
            n_pos[i] = n_nz[i] && !(sel_v[i][SAMPLE_BITS-1] ^ i_cfg.axis_negate[i]);
            n_mag[i] = sel_v[i][SAMPLE_BITS-1] ? (~sel_v[i] + 1'b1) : sel_v[i];
        end
    end

    assign n_pitch = r_sq[0] >= r_sq[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag  <= n_mag;
            r_pos1 <= n_pos;
            r_nz1  <= n_nz;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQ_W'(r_mag[i]) * SQ_W'(r_mag[i]);
            end
            r_pos2 <= r_pos1;
            r_nz2  <= r_nz1;

            r_pitch3 <= n_pitch;
            r_dom    <= n_pitch ? r_sq[0] : r_sq[1];
            r_sum    <= n_pitch ? (SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]))
                                : (SUM_W'(r_sq[0]) + SUM_W'(r_sq[2]));
            r_pos3   <= n_pitch ? r_pos2[0] : r_pos2[1];
            r_nz3    <= n_pitch ? r_nz2[0] : r_nz2[1];

            r_prod   <= PROD_W'(i_cfg.tilt_tan_sq) * PROD_W'(r_sum);
            r_lhs    <= {r_dom, {K_W{1'b0}}};
            r_pitch4 <= r_pitch3;
            r_pos4   <= r_pos3;
            r_nz4    <= r_nz3;
        end
    end

    assign over = PROD_W'(r_lhs) > r_prod;

    always_comb begin
        o_cmd = CMD_STOP;
        if (r_nz4 && over) begin
            if (r_pitch4) begin
                o_cmd = r_pos4 ? CMD_RIGHT : CMD_LEFT;
            end else begin
                o_cmd = r_pos4 ? CMD_BACK : CMD_FORWARD;
            end
        end
    end

endmodule

@@ design/atcc_queue.sv @@
// Command queue between the classifying front and the emitting back
`timescale 1ns / 1ps
module atcc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  atcc_pkg::t_cmd      i_data,
    input  logic                i_pop,
    output atcc_pkg::t_cmd      o_data,
    output atcc_pkg::t_q_status o_status
);
    import atcc_pkg::*;

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_status.full  = r_cnt == Q_CNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_cnt == '0;
    assign o_data         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ design/atcc_back.sv @@
// Back end: drop repeated commands and hold the result register
`timescale 1ns / 1ps
module atcc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atcc_pkg::t_cmd      i_cmd,
    input  atcc_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_tilt_command
);
    import atcc_pkg::*;

    t_cmd r_prev;
    logic r_ov;
    t_cmd r_out;
    logic change;

    assign o_pop          = !i_q_status.empty && (!r_ov || i_ready);
    assign change         = i_cmd != r_prev;
    assign o_valid        = r_ov;
    assign o_tilt_command = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= CMD_NONE;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop && change) begin
                r_prev <= i_cmd;
                r_ov   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && change) begin
            r_out <= i_cmd;
        end
    end

endmodule

@@ design/accel_tilt_command_classifier.sv @@
// Top level: configuration registers and the front, queue and back of the classifier
//
// Input channel i_valid/o_ready carries one signed three-axis sample per
// transaction (i_accel_x, i_accel_y, i_accel_z). Output channel
// o_valid/i_ready carries a tilt command (0 stop, 1 right, 2 left,
// 3 back, 4 forward), emitted only when it differs from the last one.
// The APB port holds tilt_tan_sq at 0x0, axis_negate at 0x4 and
// axis_select at 0x8; pready is always high.
// Throughput: one sample per cycle unless the queue is full, set by the front pipeline
// (remap, square, select and sum, threshold multiply, compare).
// Each result passes the front pipeline, queue and back register before o_valid.
// A 4-entry queue sits between the front and the back; when the receiver
// stalls the queue fills, then the front stops and o_ready falls.
// Reset restores the register defaults (identity select, all axes
// negated, 20 degree threshold) and clears the last command, so the first
// sample after reset always emits.
`timescale 1ns / 1ps
module accel_tilt_command_classifier (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [atcc_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [atcc_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [atcc_pkg::SAMPLE_BITS-1:0] i_accel_z,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [2:0]                             o_tilt_command,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [atcc_pkg::ADDR_W-1:0]            paddr,
    input  logic [atcc_pkg::DATA_W-1:0]            pwdata,
    output logic [atcc_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);
    import atcc_pkg::*;

    t_cfg      r_cfg;
    t_reg_idx  reg_idx;
    logic      wr_en;
    logic      push, pop;
    t_cmd      front_cmd, q_cmd;
    t_q_status q_status;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_tan_sq <= TILT_TAN_SQ_RST;
            r_cfg.axis_negate <= AXIS_NEGATE_RST;
            r_cfg.axis_select <= AXIS_SELECT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TILT_TAN_SQ: r_cfg.tilt_tan_sq <= pwdata[K_W-1:0];
                REG_AXIS_NEGATE: r_cfg.axis_negate <= pwdata[2:0];
                REG_AXIS_SELECT: r_cfg.axis_select <= pwdata[5:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TILT_TAN_SQ: prdata = DATA_W'(r_cfg.tilt_tan_sq);
            REG_AXIS_NEGATE: prdata = DATA_W'(r_cfg.axis_negate);
            REG_AXIS_SELECT: prdata = DATA_W'(r_cfg.axis_select);
            default:         prdata = '0;
        endcase
    end

    atcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    atcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_cmd),
        .i_pop    (pop),
        .o_data   (q_cmd),
        .o_status (q_status)
    );

    atcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_cmd),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tilt_command (o_tilt_command)
    );

endmodule

@@ design/atcc_checker.sv @@
// Checker: port-level properties of the classifier, bound to the top level
`timescale 1ns / 1ps
module atcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_tilt_command,
    input logic       pready
);
    import atcc_pkg::*;

    logic       r_seen;
    logic [2:0] r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            r_last <= o_tilt_command;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tilt_command))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tilt_command == CMD_STOP || o_tilt_command == CMD_RIGHT ||
                     o_tilt_command == CMD_LEFT || o_tilt_command == CMD_BACK ||
                     o_tilt_command == CMD_FORWARD))
        else $error("command code out of range");

    a_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(r_seen && o_tilt_command == r_last))
        else $error("repeated command emitted");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind accel_tilt_command_classifier atcc_checker u_atcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_tilt_command (o_tilt_command),
    .pready         (pready)
);

@@ tb/tb_accel_tilt_command_classifier.sv @@
// Testbench: random and directed samples through the tilt classifier, checked by a scoreboard
`timescale 1ns / 1ps
module tb_accel_tilt_command_classifier;
    import atcc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_CYCLES  = 12;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam int LONG_HOLD    = 80;

    localparam logic [5:0] SEL_IDENTITY = {SEL_Z, SEL_Y, SEL_X};
    localparam logic [5:0] SEL_SWAP     = {SEL_Z, SEL_X, SEL_Y};
    localparam logic [5:0] SEL_ALL_ZERO = {SEL_ZERO, SEL_ZERO, SEL_ZERO};
    localparam logic [5:0] SEL_ALL_X    = {SEL_X, SEL_X, SEL_X};
    localparam logic [5:0] SEL_X_OFF    = {SEL_ZERO, SEL_Y, SEL_ZERO};
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4'hC);

    typedef enum int {MIX_NOISE, MIX_DOMINANT, MIX_CORNER, MIX_REPEAT, MIX_TINY} t_mix;

    class tilt_scoreboard;
        logic [K_W-1:0] tilt_tan_sq;
        logic [2:0]     axis_negate;
        logic [5:0]     axis_select;
        t_cmd           last_cmd;
        t_cmd           expected_cmds[$];
        int             failures;

        function new();
            tilt_tan_sq = TILT_TAN_SQ_RST;
            axis_negate = AXIS_NEGATE_RST;
            axis_select = AXIS_SELECT_RST;
            last_cmd    = CMD_NONE;
            failures    = 0;
        endfunction

        function void fail(string msg);
            failures++;
            if (failures <= REPORT_MAX)
                $display("%t: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            case (t_reg_idx'(addr[ADDR_W-1:2]))
                REG_TILT_TAN_SQ: tilt_tan_sq = data[K_W-1:0];
                REG_AXIS_NEGATE: axis_negate = data[2:0];
                REG_AXIS_SELECT: axis_select = data[5:0];
                default: ;
            endcase
        endfunction

        function t_cmd classify(logic signed [SAMPLE_BITS-1:0] ax,
                                logic signed [SAMPLE_BITS-1:0] ay,
                                logic signed [SAMPLE_BITS-1:0] az);
            logic signed [SAMPLE_BITS:0] raw_axis [3];
            logic signed [SAMPLE_BITS:0] axis [3];
            longint sq [3];
            longint k;
            t_cmd cmd;
            raw_axis[0] = ax;
            raw_axis[1] = ay;
            raw_axis[2] = az;
            k = longint'(tilt_tan_sq);
            for (int i = 0; i < 3; i++) begin
                case (t_axis_sel'(axis_select[2*i +: 2]))
                    SEL_X: axis[i] = raw_axis[0];
                    SEL_Y: axis[i] = raw_axis[1];
                    SEL_Z: axis[i] = raw_axis[2];
                    default: axis[i] = '0;
                endcase
                if (axis_negate[i])
                    axis[i] = -axis[i];
                sq[i] = longint'(axis[i]) * longint'(axis[i]);
            end
            cmd = CMD_STOP;
            if (sq[0] >= sq[1]) begin
                if (axis[0] != 0 && (sq[0] << 16) > k * (sq[1] + sq[2]))
                    cmd = (axis[0] > 0) ? CMD_RIGHT : CMD_LEFT;
            end else if (axis[1] != 0 && (sq[1] << 16) > k * (sq[0] + sq[2])) begin
                cmd = (axis[1] > 0) ? CMD_BACK : CMD_FORWARD;
            end
            return cmd;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] ax,
                                  logic signed [SAMPLE_BITS-1:0] ay,
                                  logic signed [SAMPLE_BITS-1:0] az);
            t_cmd cmd;
            cmd = classify(ax, ay, az);
            if (cmd != last_cmd) begin
                expected_cmds.push_back(cmd);
                last_cmd = cmd;
            end
        endfunction

        function void check_result(logic [2:0] got);
            t_cmd want;
            if (expected_cmds.size() == 0) begin
                fail($sformatf("unexpected command %0d", got));
                return;
            end
            want = expected_cmds.pop_front();
            if (got !== want)
                fail($sformatf("tilt_command expected %0d got %0d", want, got));
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void close_out();
            if (expected_cmds.size() != 0)
                fail($sformatf("%0d commands never arrived", expected_cmds.size()));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_accel_x;
    logic signed [SAMPLE_BITS-1:0] i_accel_y;
    logic signed [SAMPLE_BITS-1:0] i_accel_z;
    logic                          o_valid;
    logic                          i_ready;
    logic [2:0]                    o_tilt_command;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ADDR_W-1:0]             paddr;
    logic [DATA_W-1:0]             pwdata;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;

    tilt_scoreboard sb = new();
    bit tx_steady;
    bit rx_steady;
    int hold_cycles;
    int idle_count;
    bit have_last;
    logic signed [SAMPLE_BITS-1:0] last_x, last_y, last_z;

    accel_tilt_command_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tilt_command (o_tilt_command),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_sample(i_accel_x, i_accel_y, i_accel_z);
            if (o_valid && i_ready)
                sb.check_result(o_tilt_command);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, 5));
    endfunction

    function automatic logic [ADDR_W-1:0] reg_addr(t_reg_idx idx);
        return ADDR_W'({idx, 2'b00});
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] corner_value();
        case ($urandom_range(0, 6))
            0: return SAMPLE_BITS'(-32768);
            1: return SAMPLE_BITS'(-32767);
            2: return SAMPLE_BITS'(-1);
            3: return SAMPLE_BITS'(0);
            4: return SAMPLE_BITS'(1);
            5: return SAMPLE_BITS'(32766);
            default: return SAMPLE_BITS'(32767);
        endcase
    endfunction

    initial begin : receiver
        int gap;
        i_ready = 1'b0;
        rx_steady = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            if ($urandom_range(0, 15) == 0)
                rx_steady = !rx_steady;
            gap = draw_gap(rx_steady);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(addr, data);
    endtask

    task automatic set_config(input logic [K_W-1:0] k, input logic [2:0] neg,
                              input logic [5:0] sel);
        reg_write(reg_addr(REG_TILT_TAN_SQ), DATA_W'(k));
        reg_write(reg_addr(REG_AXIS_NEGATE), DATA_W'(neg));
        reg_write(reg_addr(REG_AXIS_SELECT), DATA_W'(sel));
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] ax,
                               input logic signed [SAMPLE_BITS-1:0] ay,
                               input logic signed [SAMPLE_BITS-1:0] az);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_steady = !tx_steady;
        gap = draw_gap(tx_steady);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        last_x = ax;
        last_y = ay;
        last_z = az;
        have_last = 1'b1;
    endtask

    // drop valid and let the pipeline empty before touching the registers
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic gen_sample(output logic signed [SAMPLE_BITS-1:0] ax,
                              output logic signed [SAMPLE_BITS-1:0] ay,
                              output logic signed [SAMPLE_BITS-1:0] az);
        logic signed [SAMPLE_BITS-1:0] v [3];
        int pick;
        int lead;
        t_mix mix;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            mix = MIX_NOISE;
        else if (pick < 65)
            mix = MIX_DOMINANT;
        else if (pick < 78)
            mix = MIX_CORNER;
        else if (pick < 90)
            mix = MIX_REPEAT;
        else
            mix = MIX_TINY;
        if (mix == MIX_REPEAT && !have_last)
            mix = MIX_NOISE;
        lead = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            case (mix)
                MIX_DOMINANT: begin
                    if (i == lead)
                        v[i] = SAMPLE_BITS'($urandom_range(4096, 32767));
                    else
                        v[i] = SAMPLE_BITS'($urandom_range(0, 2047));
                    if ($urandom_range(0, 1))
                        v[i] = -v[i];
                end
                MIX_CORNER: v[i] = corner_value();
                MIX_TINY:   v[i] = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
                default:    v[i] = SAMPLE_BITS'($urandom());
            endcase
        end
        if (mix == MIX_REPEAT) begin
            v[0] = last_x;
            v[1] = last_y;
            v[2] = last_z;
        end
        ax = v[0];
        ay = v[1];
        az = v[2];
    endtask

    task automatic run_phase(input logic [K_W-1:0] k, input logic [2:0] neg,
                             input logic [5:0] sel, input int count);
        logic signed [SAMPLE_BITS-1:0] ax, ay, az;
        settle();
        set_config(k, neg, sel);
        repeat (count) begin
            gen_sample(ax, ay, az);
            send_sample(ax, ay, az);
        end
    endtask

    initial begin : stimulus
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_accel_x = '0;
        i_accel_y = '0;
        i_accel_z = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tx_steady = 1'b0;
        have_last = 1'b0;
        hold_cycles = 0;
        idle_count  = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: all axes negated, identity select
        send_sample(0, 0, 0);
        send_sample(0, 0, 0);
        send_sample(32767, 0, 0);
        send_sample(-32768, 0, 0);
        send_sample(0, 32767, 0);
        send_sample(0, -32768, 0);
        send_sample(0, 0, -32768);
        send_sample(-32768, -32768, -32768);
        send_sample(32767, -32768, 32767);

        // quarter threshold: hit it exactly on both angles, then just past it
        settle();
        set_config(K_W'(16384), 3'd0, SEL_IDENTITY);
        send_sample(5, 0, 10);
        send_sample(6, 0, 10);
        send_sample(0, 5, 10);
        send_sample(0, -6, 10);
        send_sample(-6, 0, 10);
        send_sample(3, 3, 0);

        settle();
        set_config(K_W'(16384), 3'd0, SEL_X_OFF);
        send_sample(32767, 100, 5);
        send_sample(-5, -200, 7);

        // hold the receiver off while commands alternate to fill the queue
        settle();
        set_config(K_W'(0), 3'd0, SEL_IDENTITY);
        hold_cycles = LONG_HOLD;
        repeat (15) begin
            send_sample(20000, 0, 0);
            send_sample(-20000, 0, 0);
        end
        run_phase(K_W'(0), 3'd0, SEL_IDENTITY, 50);
        run_phase(K_W'(16'hFFFF), 3'd7, SEL_IDENTITY, 52);
        run_phase(TILT_TAN_SQ_RST, 3'd5, SEL_SWAP, 52);
        settle();
        reg_write(UNUSED_ADDR, $urandom());
        run_phase(K_W'(30000), 3'd2, SEL_ALL_ZERO, 20);
        run_phase(K_W'(1), 3'd7, SEL_ALL_X, 40);
        repeat (4)
            run_phase(K_W'($urandom()), 3'($urandom()), 6'($urandom()), 52);
        run_phase(K_W'(16'hFFFF), 3'd0, 6'($urandom()), 52);
        run_phase(TILT_TAN_SQ_RST, AXIS_NEGATE_RST, AXIS_SELECT_RST, 52);

        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
